// File: hw/rtl/scfla_pkg.sv
package scfla_pkg;

  localparam int unsigned NUM_SIZE_CLASSES = 2048;
  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned ClsW = $clog2(NUM_SIZE_CLASSES);
  localparam int unsigned EntW = $clog2(TABLE_ENTRIES);
  localparam int unsigned FieldW = 12;

  typedef logic [FieldW-1:0] field_t;

  typedef enum logic [2:0] {
    ST_EXACT      = 3'd0,
    ST_FROM_EMPTY = 3'd1,
    ST_TRIMMED    = 3'd2,
    ST_GROWN      = 3'd3,
    ST_TOO_BIG    = 3'd4,
    ST_OUT        = 3'd5,
    ST_RELEASED   = 3'd6,
    ST_IGNORED    = 3'd7
  } status_e;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

endpackage

// File: hw/rtl/size_class_free_list_allocator.sv
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i, in_stall_o   kind_i, request_size_i, object_index_i
// out      output     out_valid_o, out_stall_i granted_index_o, status_o, needs_storage_o
//
// Exact-size allocations register their result on leaving S_NCHK and releases on leaving
// S_R2, after which the next item can be accepted in S_IDLE; too-big requests and ignored releases
// register their result at the accepting edge. Each further size class tried adds a pass
// through S_HCHK, set by the single list-head read port. After reset a clearing pass
// initialises the three memories, and the input stalls during it. The input also stalls while an item is worked on
// and while a stalled result waits in the output register.
module size_class_free_list_allocator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  scfla_pkg::field_t   request_size_i,
  input  scfla_pkg::field_t   object_index_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output scfla_pkg::field_t   granted_index_o,
  output scfla_pkg::status_e  status_o,
  output logic                needs_storage_o
);
  import scfla_pkg::*;

  localparam int unsigned ClrN =
      (TABLE_ENTRIES > NUM_SIZE_CLASSES) ? TABLE_ENTRIES : NUM_SIZE_CLASSES;
  localparam int unsigned ClrW = $clog2(ClrN);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HCHK  = 3'd2;
  localparam logic [2:0] S_NCHK  = 3'd3;
  localparam logic [2:0] S_R1    = 3'd4;
  localparam logic [2:0] S_R2    = 3'd5;

  localparam logic [1:0] PH_EXACT   = 2'd0;
  localparam logic [1:0] PH_EMPTY   = 2'd1;
  localparam logic [1:0] PH_LARGER  = 2'd2;
  localparam logic [1:0] PH_SMALLER = 2'd3;

  logic [EntW-1:0] head_mem [NUM_SIZE_CLASSES];
  logic [EntW-1:0] link_mem [TABLE_ENTRIES];
  logic [ClsW-1:0] size_mem [TABLE_ENTRIES];

  logic [2:0]      state_q, state_d;
  logic [1:0]      phase_q, phase_d;
  logic [ClsW-1:0] cls_q, cls_d;
  logic [ClsW-1:0] size_q, size_d;
  logic [EntW-1:0] pos_q, pos_d;
  logic [EntW-1:0] obj_q, obj_d;
  logic [ClrW-1:0] clr_q, clr_d;

  logic [EntW-1:0] head_rd_q, link_rd_q;
  logic [ClsW-1:0] size_rd_q;

  logic            head_we, link_we, size_we;
  logic [ClsW-1:0] head_waddr, size_wdata;
  logic [EntW-1:0] head_wdata, link_waddr, link_wdata, size_waddr;

  logic            res_load, res_storage;
  logic [EntW-1:0] res_idx;
  status_e         res_status;

  logic            out_valid_q, out_valid_d;
  field_t          out_idx_q;
  status_e         out_status_q;
  logic            out_storage_q;

  logic            in_acc, start_small, give_up;
  logic [ClsW:0]   size_nx, cls_nx, nc_w, size_w;

  assign in_stall_o = !((state_q == S_IDLE) && (!out_valid_q || !out_stall_i));
  assign in_acc = in_valid_i && !in_stall_o;

  assign size_w  = (ClsW+1)'(size_q);
  assign size_nx = size_w + (ClsW+1)'(1);
  assign cls_nx  = (ClsW+1)'(cls_q) + (ClsW+1)'(1);
  assign nc_w    = (ClsW+1)'(NUM_SIZE_CLASSES);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cls_d       = cls_q;
    size_d      = size_q;
    pos_d       = pos_q;
    obj_d       = obj_q;
    clr_d       = clr_q;
    head_we     = 1'b0;
    head_waddr  = cls_q;
    head_wdata  = link_rd_q;
    link_we     = 1'b0;
    link_waddr  = pos_q;
    link_wdata  = '0;
    size_we     = 1'b0;
    size_waddr  = pos_q;
    size_wdata  = size_q;
    res_load    = 1'b0;
    res_idx     = '0;
    res_status  = ST_OUT;
    res_storage = 1'b0;
    start_small = 1'b0;
    give_up     = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        if (32'(clr_q) < TABLE_ENTRIES) begin
          link_we    = 1'b1;
          link_waddr = clr_q[EntW-1:0];
          link_wdata = (32'(clr_q) == TABLE_ENTRIES - 1) ? '0
                                                         : EntW'(clr_q + ClrW'(1));
          size_we    = 1'b1;
          size_waddr = clr_q[EntW-1:0];
          size_wdata = '0;
        end
        if (32'(clr_q) < NUM_SIZE_CLASSES) begin
          head_we    = 1'b1;
          head_waddr = clr_q[ClsW-1:0];
          head_wdata = (clr_q == '0) ? EntW'(1) : '0;
        end
        clr_d = clr_q + ClrW'(1);
        if (32'(clr_q) == ClrN - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (kind_i == KIND_RELEASE) begin
            if (object_index_i == '0 || 32'(object_index_i) >= TABLE_ENTRIES) begin
              res_load   = 1'b1;
              res_status = ST_IGNORED;
            end else begin
              obj_d   = object_index_i[EntW-1:0];
              state_d = S_R1;
            end
          end else if (32'(request_size_i) >= NUM_SIZE_CLASSES) begin
            res_load   = 1'b1;
            res_status = ST_TOO_BIG;
          end else begin
            size_d  = request_size_i[ClsW-1:0];
            cls_d   = request_size_i[ClsW-1:0];
            phase_d = PH_EXACT;
            state_d = S_HCHK;
          end
        end
      end
      S_HCHK: begin
        if (head_rd_q != '0) begin
          pos_d   = head_rd_q;
          state_d = S_NCHK;
        end else begin
          unique case (phase_q)
            PH_EXACT: begin
              cls_d   = '0;
              phase_d = PH_EMPTY;
            end
            PH_EMPTY: begin
              if (size_nx < nc_w) begin
                cls_d   = size_nx[ClsW-1:0];
                phase_d = PH_LARGER;
              end else begin
                start_small = 1'b1;
              end
            end
            PH_LARGER: begin
              if (cls_nx < nc_w) begin
                cls_d = cls_nx[ClsW-1:0];
              end else begin
                start_small = 1'b1;
              end
            end
            PH_SMALLER: begin
              if (cls_nx < size_w) begin
                cls_d = cls_nx[ClsW-1:0];
              end else begin
                give_up = 1'b1;
              end
            end
          endcase
          if (start_small) begin
            if (size_q > ClsW'(1)) begin
              cls_d   = ClsW'(1);
              phase_d = PH_SMALLER;
            end else begin
              give_up = 1'b1;
            end
          end
          if (give_up) begin
            res_load   = 1'b1;
            res_status = ST_OUT;
            state_d    = S_IDLE;
          end
        end
      end
      S_NCHK: begin
        head_we    = 1'b1;
        head_waddr = cls_q;
        head_wdata = link_rd_q;
        link_we    = 1'b1;
        link_waddr = pos_q;
        link_wdata = '0;
        size_we    = 1'b1;
        size_waddr = pos_q;
        size_wdata = size_q;
        res_load   = 1'b1;
        res_idx    = pos_q;
        unique case (phase_q)
          PH_EXACT:   res_status = ST_EXACT;
          PH_EMPTY:   res_status = ST_FROM_EMPTY;
          PH_LARGER:  res_status = ST_TRIMMED;
          PH_SMALLER: res_status = ST_GROWN;
        endcase
        res_storage = (phase_q == PH_EMPTY) || (phase_q == PH_SMALLER);
        state_d     = S_IDLE;
      end
      S_R1: begin
        cls_d   = size_rd_q;
        state_d = S_R2;
      end
      S_R2: begin
        link_we    = 1'b1;
        link_waddr = obj_q;
        link_wdata = head_rd_q;
        head_we    = 1'b1;
        head_waddr = cls_q;
        head_wdata = obj_q;
        res_load   = 1'b1;
        res_status = ST_RELEASED;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rd_q <= head_mem[cls_d];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd_q <= link_mem[head_rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (size_we) begin
      size_mem[size_waddr] <= size_wdata;
    end
    size_rd_q <= size_mem[object_index_i[EntW-1:0]];
  end

  assign out_valid_d = res_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;
    cls_q   <= cls_d;
    size_q  <= size_d;
    pos_q   <= pos_d;
    obj_q   <= obj_d;
    if (res_load) begin
      out_idx_q     <= FieldW'(res_idx);
      out_status_q  <= res_status;
      out_storage_q <= res_storage;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_index_o = out_idx_q;
  assign status_o        = out_status_q;
  assign needs_storage_o = out_storage_q;

endmodule

// File: dv/scfla_checker.sv
module scfla_checker
  import scfla_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        kind_i,
  input  field_t      request_size_i,
  input  field_t      object_index_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  field_t      granted_index_i,
  input  status_e     status_i,
  input  logic        needs_storage_i,
  output int unsigned error_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned fallback_o,
  output int unsigned exhausted_o
);

  typedef struct packed {
    field_t  granted;
    status_e status;
    logic    storage;
  } answer_t;

  field_t           class_head  [NUM_SIZE_CLASSES];
  field_t           free_link   [TABLE_ENTRIES];
  logic [ClsW-1:0]  stored_size [TABLE_ENTRIES];
  answer_t          awaited_q   [$];

  int unsigned mismatches = 0;
  int unsigned checked = 0;
  int unsigned fallbacks = 0;
  int unsigned exhausted = 0;
  int unsigned waiting = 0;

  assign error_count_o = mismatches;
  assign pending_o = waiting;
  assign checked_o = checked;
  assign fallback_o = fallbacks;
  assign exhausted_o = exhausted;

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("%0t: MISMATCH %s", $time, msg);
  endtask

  function automatic field_t pop_free(input int unsigned cls);
    field_t pos;
    pos = (class_head[cls] < TABLE_ENTRIES) ? class_head[cls] : '0;
    if (pos != '0) begin
      class_head[cls] = (free_link[pos] < TABLE_ENTRIES) ? free_link[pos] : '0;
    end
    return pos;
  endfunction

  function automatic answer_t serve(input logic kind, input field_t size, input field_t idx);
    answer_t     ans;
    field_t      pos;
    int unsigned cls;
    ans.granted = '0;
    ans.status = ST_IGNORED;
    ans.storage = 1'b0;
    if (kind == KIND_RELEASE) begin
      if (idx != '0 && idx < TABLE_ENTRIES) begin
        cls = stored_size[idx];
        if (cls >= NUM_SIZE_CLASSES) cls = 0;
        free_link[idx] = class_head[cls];
        class_head[cls] = idx;
        ans.status = ST_RELEASED;
      end
    end else if (size >= NUM_SIZE_CLASSES) begin
      ans.status = ST_TOO_BIG;
    end else begin
      pos = pop_free(size);
      ans.status = ST_EXACT;
      if (pos == '0) begin
        pos = pop_free(0);
        ans.status = ST_FROM_EMPTY;
        ans.storage = 1'b1;
      end
      if (pos == '0) begin
        ans.status = ST_TRIMMED;
        ans.storage = 1'b0;
        for (cls = size + 1; cls < NUM_SIZE_CLASSES && pos == '0; cls++) pos = pop_free(cls);
        if (pos == '0) begin
          ans.status = ST_GROWN;
          ans.storage = 1'b1;
          for (cls = 1; cls < size && pos == '0; cls++) pos = pop_free(cls);
        end
      end
      if (pos == '0) begin
        ans.status = ST_OUT;
        ans.storage = 1'b0;
      end else begin
        stored_size[pos] = size[ClsW-1:0];
        free_link[pos] = '0;
        ans.granted = pos;
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SIZE_CLASSES; i++) class_head[i] = '0;
      class_head[0] = field_t'(1);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        free_link[i] = (i + 1 < TABLE_ENTRIES) ? field_t'(i + 1) : '0;
        stored_size[i] = '0;
      end
      awaited_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        awaited_q.push_back(serve(kind_i, request_size_i, object_index_i));
      end
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (awaited_q.size() == 0) begin
          flag_mismatch($sformatf("result with no item outstanding: index %0d status %0d",
                                  granted_index_i, status_i));
        end else begin
          want = awaited_q.pop_front();
          if (granted_index_i !== want.granted)
            flag_mismatch($sformatf("granted_index got %0d, expected %0d",
                                    granted_index_i, want.granted));
          if (status_i !== want.status)
            flag_mismatch($sformatf("status got %0d, expected %0d", status_i, want.status));
          if (needs_storage_i !== want.storage)
            flag_mismatch($sformatf("needs_storage got %0b, expected %0b",
                                    needs_storage_i, want.storage));
          if (want.status == ST_TRIMMED || want.status == ST_GROWN) fallbacks++;
          if (want.status == ST_OUT) exhausted++;
        end
      end
    end
    waiting = awaited_q.size();
  end

endmodule

// File: dv/size_class_free_list_allocator_tb.sv
module size_class_free_list_allocator_tb;
  import scfla_pkg::*;

  localparam int unsigned ItemTarget = 1423;
  localparam int unsigned SpareFirst = 3968;
  localparam int unsigned SpareCount = 64;
  localparam int unsigned FreshFirst = 2048;

  logic    clk_i;
  logic    rst_ni;
  logic    in_valid_i;
  logic    in_stall_o;
  logic    kind_i;
  field_t  request_size_i;
  field_t  object_index_i;
  logic    out_valid_o;
  logic    out_stall_i;
  field_t  granted_index_o;
  status_e status_o;
  logic    needs_storage_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned fallbacks;
  int unsigned exhausted;

  logic        long_hold_req = 1'b0;
  bit          sender_steady = 1'b0;
  int unsigned items_sent = 0;
  int unsigned allocs_sent = 0;
  int unsigned releases_sent = 0;
  int unsigned fresh_next = FreshFirst;
  field_t      granted_pool [$];

  size_class_free_list_allocator dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .kind_i,
    .request_size_i,
    .object_index_i,
    .out_valid_o,
    .out_stall_i,
    .granted_index_o,
    .status_o,
    .needs_storage_o
  );

  scfla_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i      (in_stall_o),
    .kind_i,
    .request_size_i,
    .object_index_i,
    .out_valid_i     (out_valid_o),
    .out_stall_i,
    .granted_index_i (granted_index_o),
    .status_i        (status_o),
    .needs_storage_i (needs_storage_o),
    .error_count_o   (mismatches),
    .pending_o       (pending),
    .checked_o       (checked),
    .fallback_o      (fallbacks),
    .exhausted_o     (exhausted)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #(240_000_000);
    $display("Timeout: the run did not finish in time.");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Granted entries are remembered so that some releases return real allocations.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i && granted_index_o != '0 &&
        (granted_index_o < SpareFirst || granted_index_o >= SpareFirst + SpareCount)) begin
      granted_pool.push_back(granted_index_o);
      if (granted_pool.size() > 256) void'(granted_pool.pop_front());
    end
  end

  initial begin
    int unsigned stall_left;
    int unsigned results_seen;
    bit          quiet;
    bit          hold_done;
    out_stall_i = 1'b0;
    stall_left = 0;
    results_seen = 0;
    quiet = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        stall_left = 200;
        out_stall_i <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (results_seen % 50 == 0) quiet = ($urandom_range(0, 2) == 0);
        stall_left = quiet ? 0 : $urandom_range(0, 3);
        if (stall_left != 0) out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        if (stall_left == 0) out_stall_i <= 1'b0;
      end
    end
  end

  task automatic offer(input logic kind, input field_t size, input field_t idx);
    int unsigned gap;
    gap = sender_steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    request_size_i <= size;
    object_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if (kind == KIND_ALLOC) allocs_sent++;
    else releases_sent++;
  endtask

  task automatic alloc_item(input field_t size);
    offer(KIND_ALLOC, size, field_t'($urandom_range(0, 4095)));
  endtask

  task automatic release_item(input field_t idx);
    offer(KIND_RELEASE, field_t'($urandom_range(0, 4095)), idx);
  endtask

  function automatic field_t draw_size();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return field_t'($urandom_range(0, 7));
    if (pick < 90) return field_t'($urandom_range(0, 63));
    if (pick < 97) return field_t'($urandom_range(0, NUM_SIZE_CLASSES - 1));
    return field_t'($urandom_range(NUM_SIZE_CLASSES, 4095));
  endfunction

  // Entries that have never been handed out still carry size zero.
  function automatic field_t next_fresh();
    field_t idx;
    idx = field_t'(fresh_next);
    fresh_next = (fresh_next == SpareFirst - 1) ? FreshFirst : fresh_next + 1;
    return idx;
  endfunction

  function automatic field_t pick_granted(input bit keep);
    int unsigned slot;
    field_t      found;
    if (granted_pool.size() == 0) return next_fresh();
    slot = $urandom_range(0, granted_pool.size() - 1);
    found = granted_pool[slot];
    if (!keep) begin
      granted_pool[slot] = granted_pool[granted_pool.size() - 1];
      void'(granted_pool.pop_back());
    end
    return found;
  endfunction

  function automatic field_t stray_index();
    int unsigned idx;
    idx = $urandom_range(0, 4095 - SpareCount);
    if (idx >= SpareFirst) idx += SpareCount;
    return field_t'(idx);
  endfunction

  initial begin
    int unsigned pick;
    int unsigned drains;
    int unsigned waited;
    bit          hold_started;
    field_t      spare;
    in_valid_i = 1'b0;
    kind_i = KIND_ALLOC;
    request_size_i = '0;
    object_index_i = '0;
    drains = 0;
    hold_started = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    alloc_item(field_t'(0));
    alloc_item(field_t'(3));
    alloc_item(field_t'(NUM_SIZE_CLASSES));
    alloc_item(field_t'(4095));
    release_item(field_t'(0));
    release_item(field_t'(2));
    alloc_item(field_t'(3));
    // Releasing an entry twice turns the size-zero list into a loop that ends after two pops.
    release_item(field_t'(1));
    release_item(field_t'(1));
    alloc_item(field_t'(0));
    alloc_item(field_t'(0));
    alloc_item(field_t'(5));
    release_item(field_t'(2));
    alloc_item(field_t'(1));
    release_item(field_t'(2));
    alloc_item(field_t'(NUM_SIZE_CLASSES - 1));
    release_item(field_t'(2));
    alloc_item(field_t'(0));
    release_item(field_t'(2));
    alloc_item(field_t'(NUM_SIZE_CLASSES - 1));
    release_item(field_t'(4095));
    alloc_item(field_t'(0));
    release_item(field_t'(4095));

    while (items_sent < ItemTarget) begin
      sender_steady = ($urandom_range(0, 3) == 0);
      if (!hold_started && items_sent >= 500) begin
        hold_started = 1'b1;
        sender_steady = 1'b1;
        long_hold_req <= 1'b1;
      end
      if ($urandom_range(0, 11) == 0) begin
        drains++;
        spare = field_t'(SpareFirst + $urandom_range(0, SpareCount - 1));
        release_item(spare);
        release_item(spare);
        alloc_item(field_t'(0));
        alloc_item(field_t'(0));
        repeat (10) begin
          if ($urandom_range(0, 1) == 0) alloc_item(field_t'($urandom_range(0, 7)));
          else alloc_item(field_t'($urandom_range(0, NUM_SIZE_CLASSES - 1)));
        end
      end else begin
        repeat (20) begin
          pick = $urandom_range(0, 99);
          if (pick < 40) alloc_item(draw_size());
          else if (pick < 60) release_item(pick_granted(1'b0));
          else if (pick < 90) release_item(next_fresh());
          else if (pick < 93) release_item('0);
          else if (pick < 96) release_item(pick_granted(1'b1));
          else release_item(stray_index());
        end
      end
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);

    if (pending != 0) $display("%0d expected results never arrived.", pending);
    $display("Drove %0d items (%0d allocations, %0d releases) with %0d list drains",
             items_sent, allocs_sent, releases_sent, drains);
    $display("and one long output hold; checked %0d results: %0d from another size class, %0d with nothing free.",
             checked, fallbacks, exhausted);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
